// ===== rtl/rssi_device_tracker_unit_defines.svh =====
// assertion macros shared by the checker
`ifndef RSSI_DEVICE_TRACKER_UNIT_DEFINES_SVH
`define RSSI_DEVICE_TRACKER_UNIT_DEFINES_SVH

// property checked outside reset
`define RDT_ASSERT_CHK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rdt assertion failed");

// property checked in every cycle, reset included
`define RDT_ASSERT_ANY(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rdt assertion failed");

`endif

// ===== rtl/rdt_pkg.sv =====
`timescale 1ns / 1ps
package rdt_pkg;

   localparam int DEVICES = 16;
   localparam int SAMPLES = 16;
   localparam int TOTAL   = DEVICES * SAMPLES;

   localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int SLOT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int CNT_W  = $clog2(SAMPLES + 1);
   localparam int LIN_W  = 43;
   localparam int SUM_W  = LIN_W + $clog2(SAMPLES);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int MAC_W  = 48;
   localparam int TIME_W = 48;
   localparam int LVL_W  = 8;
   localparam int AGE_W  = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_LEVEL = 2'd1;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET     = 32'd1000000;
   localparam logic [LVL_W-1:0] EMPTY_LEVEL_RESET = 8'hA1;
   localparam logic [7:0]       LIN_LAST          = 8'd128;
   localparam logic [7:0]       LEVEL_FLIP        = 8'h80;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_EXPIRE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_REPLACED = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_SEARCH,
      CMD_FAIL,
      CMD_ALLOC,
      CMD_SLOT,
      CMD_OLD_SCAN,
      CMD_WRITE,
      CMD_EXP_SCAN,
      CMD_SUM_INIT,
      CMD_SUM_SCAN,
      CMD_DIV_START,
      CMD_LOOKUP,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   found;
      logic   has_free;
      logic   has_empty;
      logic   scan_done;
      logic   cnt_zero;
      logic   div_done;
      logic   lookup_done;
   } dp_status_type;

   typedef logic [LIN_W-1:0] lin_table_type [0:128];

   // 10^(k/10) rounded, built from the mantissas of one decade
   function automatic lin_table_type build_lin();
      lin_table_type t;
      logic [63:0] m [0:9];
      logic [63:0] x;
      logic [63:0] half;
      int q;
      int j;
      int n;
      m[0] = 64'd1000000000000;
      m[1] = 64'd1258925411794;
      m[2] = 64'd1584893192461;
      m[3] = 64'd1995262314969;
      m[4] = 64'd2511886431510;
      m[5] = 64'd3162277660168;
      m[6] = 64'd3981071705535;
      m[7] = 64'd5011872336273;
      m[8] = 64'd6309573444802;
      m[9] = 64'd7943282347243;
      for (int k = 0; k <= 128; k++) begin
         q = k / 10;
         j = k % 10;
         if (q >= 12) begin
            x = m[j];
         end else begin
            half = 64'd5;
            for (n = q; n < 11; n++) half = half * 64'd10;
            x = m[j] + half;
            for (n = q; n < 12; n++) x = x / 64'd10;
         end
         t[k] = x[LIN_W-1:0];
      end
      return t;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin();

   function automatic logic [LIN_W-1:0] lin_of(input logic [7:0] k);
      logic [7:0] kk;
      kk = (k > LIN_LAST) ? LIN_LAST : k;
      return LIN_TABLE[kk];
   endfunction

endpackage

// ===== rtl/rssi_device_tracker_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tuser op, tdata mac rssi_dbm now_us
// rsp       out        rsp_tvalid/rsp_tready  tdata found avg_dbm sample_count status
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// one request at a time; clear all writes the result register directly
// unknown device: fails after the search unless an add allocates it; add, expire
// or query walk the sample store one slot a cycle (two passes on expire, and on an
// add with no empty slot), then, if any sample counts, the bit-serial mean divider
// and a binary dB search; reset is synchronous, no sweep
// a new request is taken while the last result still waits in rsp
module rssi_device_tracker_unit import rdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // op
   input  logic [1:0]           req_tuser,
   // mac[47:0], rssi_dbm[55:48], now_us[103:56]
   input  logic [103:0]         req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // found[0], avg_dbm[8:1], sample_count[13:9], status[15:14]
   output logic [15:0]          rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cmd_type       cmd;
   dp_status_type stat;
   logic          rsp_load;
   logic          rsp_found;
   logic [7:0]    rsp_avg;
   logic [4:0]    rsp_count;
   logic [1:0]    rsp_status;

   assign csr_ready = 1'b1;

   rdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_load   (rsp_load)
   );

   rdt_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_op     (req_tuser),
      .req_mac    (req_tdata[47:0]),
      .req_rssi   (req_tdata[55:48]),
      .req_now    (req_tdata[103:56]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_load   (rsp_load),
      .rsp_found  (rsp_found),
      .rsp_avg    (rsp_avg),
      .rsp_count  (rsp_count),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {rsp_status, rsp_count, rsp_avg, rsp_found};

endmodule

// ===== rtl/rdt_divider.sv =====
`timescale 1ns / 1ps
module rdt_divider import rdt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              have_ff, have_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    diff;
   logic              ge;

   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign ge     = rem_sh >= {1'b0, divisor};
   assign diff   = rem_sh - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      have_in = have_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         have_in = 1'b0;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         rem_in  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            have_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         have_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         have_ff <= have_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = have_ff && !busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/rdt_ctrl.sv =====
`timescale 1ns / 1ps
module rdt_ctrl import rdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic [1:0]    req_op,
   output logic          req_tready,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   input  dp_status_type stat,
   output cmd_type       cmd,
   output logic          rsp_load
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_CLEAR,
      S_SEARCH,
      S_DECIDE,
      S_FAIL,
      S_ALLOC,
      S_SLOT,
      S_OLDEST,
      S_WRITE,
      S_EXPIRE,
      S_SUM_PREP,
      S_SUM,
      S_DIV_START,
      S_DIV_WAIT,
      S_LOOKUP,
      S_FINISH,
      S_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_load   = (state_ff == S_RESPOND) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = CMD_NONE;
      case (state_ff)
         S_IDLE:      cmd = req_tvalid ? CMD_LOAD : CMD_NONE;
         S_CLEAR:     cmd = CMD_CLEAR;
         S_SEARCH:    cmd = CMD_SEARCH;
         S_FAIL:      cmd = CMD_FAIL;
         S_ALLOC:     cmd = CMD_ALLOC;
         S_SLOT:      cmd = CMD_SLOT;
         S_OLDEST:    cmd = CMD_OLD_SCAN;
         S_WRITE:     cmd = CMD_WRITE;
         S_EXPIRE:    cmd = CMD_EXP_SCAN;
         S_SUM_PREP:  cmd = CMD_SUM_INIT;
         S_SUM:       cmd = CMD_SUM_SCAN;
         S_DIV_START: cmd = CMD_DIV_START;
         S_LOOKUP:    cmd = CMD_LOOKUP;
         S_FINISH:    cmd = CMD_FINISH;
         default:     cmd = CMD_NONE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (op_type'(req_op) == OP_CLEAR) ? S_CLEAR : S_SEARCH;
            end
         end
         S_CLEAR:  state_in = S_RESPOND;
         S_SEARCH: state_in = S_DECIDE;
         S_DECIDE: begin
            if (stat.found) begin
               case (stat.op)
                  OP_ADD:    state_in = S_SLOT;
                  OP_EXPIRE: state_in = S_EXPIRE;
                  default:   state_in = S_SUM_PREP;
               endcase
            end else if (stat.op == OP_ADD && stat.has_free) begin
               state_in = S_ALLOC;
            end else begin
               state_in = S_FAIL;
            end
         end
         S_FAIL:  state_in = S_RESPOND;
         S_ALLOC: state_in = S_SLOT;
         S_SLOT:  state_in = stat.has_empty ? S_WRITE : S_OLDEST;
         S_OLDEST: begin
            if (stat.scan_done) state_in = S_WRITE;
         end
         S_WRITE: state_in = S_SUM_PREP;
         S_EXPIRE: begin
            if (stat.scan_done) state_in = S_SUM_PREP;
         end
         S_SUM_PREP: state_in = S_SUM;
         S_SUM: begin
            if (stat.scan_done) state_in = stat.cnt_zero ? S_FINISH : S_DIV_START;
         end
         S_DIV_START: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (stat.div_done) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            if (stat.lookup_done) state_in = S_FINISH;
         end
         S_FINISH: state_in = S_RESPOND;
         S_RESPOND: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/rdt_datapath.sv =====
`timescale 1ns / 1ps
module rdt_datapath import rdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   input  logic [1:0]           req_op,
   input  logic [MAC_W-1:0]     req_mac,
   input  logic [LVL_W-1:0]     req_rssi,
   input  logic [TIME_W-1:0]    req_now,
   input  cmd_type              cmd,
   output dp_status_type        stat,
   input  logic                 rsp_load,
   output logic                 rsp_found,
   output logic [7:0]           rsp_avg,
   output logic [4:0]           rsp_count,
   output logic [1:0]           rsp_status
);

   // control state
   logic [AGE_W-1:0]  max_age_ff, max_age_in;
   logic [LVL_W-1:0]  empty_ff, empty_in;
   logic [DEVICES-1:0] dev_valid_ff, dev_valid_in;
   logic [TOTAL-1:0]  samp_valid_ff, samp_valid_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              p_act_ff, p_act_in;

   // payload
   op_type            op_ff, op_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [MAC_W-1:0]  dev_mac_ff [DEVICES];
   logic [MAC_W-1:0]  dev_mac_in [DEVICES];
   logic              found_ff, found_in;
   logic              has_free_ff, has_free_in;
   logic [DEV_W-1:0]  dev_ff, dev_in;
   logic [DEV_W-1:0]  free_ff, free_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   status_code_type   status_ff, status_in;
   logic [SLOT_W-1:0] p_idx_ff, p_idx_in;
   logic [ADDR_W-1:0] p_addr_ff, p_addr_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]        lo_ff, lo_in;
   logic [7:0]        hi_ff, hi_in;
   logic              res_found_ff, res_found_in;
   logic [7:0]        res_level_ff, res_level_in;
   logic [4:0]        res_count_ff, res_count_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_found_ff;
   logic [7:0]        rsp_avg_ff;
   logic [4:0]        rsp_count_ff;
   logic [1:0]        rsp_status_ff;

   // sample store
   logic [LVL_W-1:0]  sample_level_mem [TOTAL];
   logic [TIME_W-1:0] sample_time_mem [TOTAL];
   logic [LVL_W-1:0]  rd_level_ff;
   logic [TIME_W-1:0] rd_time_ff;

   logic              hit_any, free_any, has_empty;
   logic [DEV_W-1:0]  hit_idx, free_idx;
   logic [SLOT_W-1:0] empty_idx;
   logic [ADDR_W-1:0] base, rd_addr, slot_addr;
   logic              is_scan, issuing, scan_done, age_ok;
   logic [LIN_W-1:0]  lin_val;
   logic [8:0]        mid_sum;
   logic [7:0]        mid;
   logic              div_start, div_done;
   logic [SUM_W-1:0]  quotient;

   assign base      = ADDR_W'(dev_ff) * ADDR_W'(SAMPLES);
   assign rd_addr   = base + ADDR_W'(scan_ff[SLOT_W-1:0]);
   assign slot_addr = base + ADDR_W'(slot_ff);
   assign is_scan   = (cmd == CMD_OLD_SCAN) || (cmd == CMD_EXP_SCAN) || (cmd == CMD_SUM_SCAN);
   assign issuing   = is_scan && (scan_ff < CNT_W'(SAMPLES));
   assign scan_done = (scan_ff == CNT_W'(SAMPLES)) && !p_act_ff;
   assign age_ok    = samp_valid_ff[p_addr_ff] && (now_ff >= rd_time_ff)
                      && ((now_ff - rd_time_ff) >= TIME_W'(max_age_ff));
   assign lin_val   = lin_of(rd_level_ff ^ LEVEL_FLIP);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[8:1];
   assign div_start = (cmd == CMD_DIV_START);

   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = DEVICES - 1; i >= 0; i--) begin
         if (dev_valid_ff[i] && dev_mac_ff[i] == mac_ff) begin
            hit_any = 1'b1;
            hit_idx = DEV_W'(i);
         end
         if (!dev_valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = DEV_W'(i);
         end
      end
   end

   always_comb begin
      has_empty = 1'b0;
      empty_idx = '0;
      for (int s = SAMPLES - 1; s >= 0; s--) begin
         if (!samp_valid_ff[base + ADDR_W'(s)]) begin
            has_empty = 1'b1;
            empty_idx = SLOT_W'(s);
         end
      end
   end

   rdt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      max_age_in    = max_age_ff;
      empty_in      = empty_ff;
      dev_valid_in  = dev_valid_ff;
      samp_valid_in = samp_valid_ff;
      scan_in       = is_scan ? scan_ff : '0;
      p_act_in      = 1'b0;
      op_in         = op_ff;
      mac_in        = mac_ff;
      lvl_in        = lvl_ff;
      now_in        = now_ff;
      dev_mac_in    = dev_mac_ff;
      found_in      = found_ff;
      has_free_in   = has_free_ff;
      dev_in        = dev_ff;
      free_in       = free_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      p_idx_in      = scan_ff[SLOT_W-1:0];
      p_addr_in     = rd_addr;
      best_in       = best_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      res_found_in  = res_found_ff;
      res_level_in  = res_level_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_AGE:     max_age_in = csr_data;
            CSR_EMPTY_LEVEL: empty_in = csr_data[LVL_W-1:0];
            default: ;
         endcase
      end

      if (issuing) begin
         scan_in  = scan_ff + 1'b1;
         p_act_in = 1'b1;
      end

      case (cmd)
         CMD_LOAD: begin
            op_in  = op_type'(req_op);
            mac_in = req_mac;
            lvl_in = (!req_rssi[LVL_W-1] && req_rssi != '0) ? '0 : req_rssi;
            now_in = req_now;
         end
         CMD_CLEAR: begin
            dev_valid_in  = '0;
            samp_valid_in = '0;
            res_found_in  = 1'b0;
            res_level_in  = empty_ff;
            res_count_in  = '0;
            res_status_in = ST_OK;
         end
         CMD_SEARCH: begin
            found_in    = hit_any;
            dev_in      = hit_idx;
            free_in     = free_idx;
            has_free_in = free_any;
            status_in   = ST_OK;
         end
         CMD_FAIL: begin
            res_found_in  = 1'b0;
            res_level_in  = empty_ff;
            res_count_in  = '0;
            res_status_in = (op_ff == OP_ADD) ? ST_FULL : ST_OK;
         end
         CMD_ALLOC: begin
            dev_valid_in[free_ff] = 1'b1;
            dev_mac_in[free_ff]   = mac_ff;
            dev_in                = free_ff;
         end
         CMD_SLOT: begin
            slot_in   = has_empty ? empty_idx : '0;
            status_in = has_empty ? ST_OK : ST_REPLACED;
         end
         CMD_OLD_SCAN: begin
            if (p_act_ff && (p_idx_ff == '0 || rd_time_ff < best_ff)) begin
               best_in = rd_time_ff;
               slot_in = p_idx_ff;
            end
         end
         CMD_WRITE: samp_valid_in[slot_addr] = 1'b1;
         CMD_EXP_SCAN: begin
            if (p_act_ff && age_ok) samp_valid_in[p_addr_ff] = 1'b0;
         end
         CMD_SUM_INIT: begin
            sum_in = '0;
            cnt_in = '0;
         end
         CMD_SUM_SCAN: begin
            if (p_act_ff && samp_valid_ff[p_addr_ff]) begin
               sum_in = sum_ff + SUM_W'(lin_val);
               cnt_in = cnt_ff + 1'b1;
            end
         end
         CMD_DIV_START: begin
            lo_in = '0;
            hi_in = LIN_LAST;
         end
         CMD_LOOKUP: begin
            if (lo_ff < hi_ff) begin
               if (SUM_W'(lin_of(mid)) >= quotient) hi_in = mid;
               else lo_in = mid + 1'b1;
            end
         end
         CMD_FINISH: begin
            res_found_in  = found_ff;
            res_level_in  = (cnt_ff == '0) ? empty_ff : (lo_ff ^ LEVEL_FLIP);
            res_count_in  = (32'(cnt_ff) > 32'd31) ? 5'd31 : 5'(cnt_ff);
            res_status_in = status_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff    <= MAX_AGE_RESET;
         empty_ff      <= EMPTY_LEVEL_RESET;
         dev_valid_ff  <= '0;
         samp_valid_ff <= '0;
         scan_ff       <= '0;
         p_act_ff      <= 1'b0;
      end else begin
         max_age_ff    <= max_age_in;
         empty_ff      <= empty_in;
         dev_valid_ff  <= dev_valid_in;
         samp_valid_ff <= samp_valid_in;
         scan_ff       <= scan_in;
         p_act_ff      <= p_act_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      mac_ff        <= mac_in;
      lvl_ff        <= lvl_in;
      now_ff        <= now_in;
      dev_mac_ff    <= dev_mac_in;
      found_ff      <= found_in;
      has_free_ff   <= has_free_in;
      dev_ff        <= dev_in;
      free_ff       <= free_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      p_idx_ff      <= p_idx_in;
      p_addr_ff     <= p_addr_in;
      best_ff       <= best_in;
      sum_ff        <= sum_in;
      cnt_ff        <= cnt_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_found_ff  <= res_found_in;
      res_level_ff  <= res_level_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_found_ff  <= res_found_ff;
         rsp_avg_ff    <= res_level_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_WRITE) begin
         sample_level_mem[slot_addr] <= lvl_ff;
         sample_time_mem[slot_addr]  <= now_ff;
      end
      rd_level_ff <= sample_level_mem[rd_addr];
      rd_time_ff  <= sample_time_mem[rd_addr];
   end

   assign stat.op          = op_ff;
   assign stat.found       = found_ff;
   assign stat.has_free    = has_free_ff;
   assign stat.has_empty   = has_empty;
   assign stat.scan_done   = scan_done;
   assign stat.cnt_zero    = (cnt_ff == '0);
   assign stat.div_done    = div_done;
   assign stat.lookup_done = (lo_ff >= hi_ff);

   assign rsp_found  = rsp_found_ff;
   assign rsp_avg    = rsp_avg_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/rdt_checker.sv =====
`timescale 1ns / 1ps
`include "rssi_device_tracker_unit_defines.svh"
module rdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   `RDT_ASSERT_ANY(a_reset_idle, clock, reset |=> !rsp_tvalid)
   `RDT_ASSERT_CHK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `RDT_ASSERT_CHK(a_level_nonpos, clock, reset, rsp_tvalid |-> rsp_tdata[8] || rsp_tdata[8:1] == 8'd0)
   `RDT_ASSERT_CHK(a_full_empty, clock, reset, rsp_tvalid && rsp_tdata[15:14] == 2'd1 |-> !rsp_tdata[0] && rsp_tdata[13:9] == 5'd0)

endmodule

bind rssi_device_tracker_unit rdt_checker u_rdt_checker (.*);
